// File: hw/rtl/jtfe_pkg.sv
// ----------------------------------------------------------------------------
// jtfe_pkg
// Shared types and constants of the JSON text field extractor.
// ----------------------------------------------------------------------------
package jtfe_pkg;

    // Parser modes
    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_STRING = 2'd1,
        MODE_ESCAPE = 2'd2,
        MODE_HEX    = 2'd3
    } mode_t;

    // Payload of one input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_end;
    } in_item_t;

    // Payload of one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_done;
    } out_item_t;

    // All results caused by one input item; cnt is 1 to 3
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            data_valid;
        logic            done;
    } group_t;

endpackage

// File: hw/rtl/jtfe_stream_if.sv
// ----------------------------------------------------------------------------
// jtfe_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface jtfe_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// File: hw/rtl/jtfe_front.sv
// ----------------------------------------------------------------------------
// jtfe_front
// Byte parser: key search, string pass-through, escape and \u decoding.
// Pushes one group of up to three result bytes per accepted item that yields any.
// ----------------------------------------------------------------------------
module jtfe_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  jtfe_pkg::in_item_t in_data,
    input  logic             queue_full,
    output logic             push,
    output jtfe_pkg::group_t grp
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [2:0] KEY_LAST = 3'd7;
    localparam logic [2:0] KEY_FALLBACK_AT = 3'd6;
    localparam logic [7:0][7:0] KEY = {8'h22, 8'h3A, 8'h22, 8'h74,
                                        8'h78, 8'h65, 8'h74, 8'h22};

    jtfe_pkg::mode_t mode_reg, mode_next;
    logic [2:0]      key_reg, key_next;
    logic [1:0]      hex_cnt_reg, hex_cnt_next;
    logic [11:0]     cp_reg, cp_next;

    logic            accept;
    logic [7:0]      c;
    logic            last;
    logic [3:0]      hv;
    logic [15:0]     cp_full;

    function automatic logic [3:0] hex_value(input logic [7:0] h);
        logic [3:0] v;
        v = 4'd0;
        if (h >= 8'h30 && h <= 8'h39) v = 4'(h - 8'h30);
        else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h57);
        else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h37);
        return v;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign c        = in_data.in_byte;
    assign last     = in_data.msg_end;
    assign hv       = hex_value(c);
    assign cp_full  = {cp_reg, hv};

    // Next state
    always_comb
    begin
        mode_next    = mode_reg;
        key_next     = key_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        unique case (mode_reg)
            jtfe_pkg::MODE_SEARCH:
            begin
                if (c == KEY[key_reg])
                begin
                    if (key_reg == KEY_LAST)
                    begin
                        mode_next = jtfe_pkg::MODE_STRING;
                        key_next  = 3'd0;
                    end
                    else
                    begin
                        key_next = key_reg + 3'd1;
                    end
                end
                else if (key_reg == KEY_FALLBACK_AT && c == CH_T)
                    key_next = 3'd2;  // the matched "text" closes in a quote
                else if (c == CH_QUOTE)
                    key_next = 3'd1;
                else
                    key_next = 3'd0;
            end
            jtfe_pkg::MODE_STRING:
            begin
                if (c == CH_BSL)
                begin
                    if (!last) mode_next = jtfe_pkg::MODE_ESCAPE;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = jtfe_pkg::MODE_SEARCH;
                    key_next  = 3'd0;
                end
            end
            jtfe_pkg::MODE_ESCAPE:
            begin
                if (c == CH_U)
                begin
                    mode_next    = jtfe_pkg::MODE_HEX;
                    hex_cnt_next = 2'd0;
                    cp_next      = 12'd0;
                end
                else
                begin
                    mode_next = jtfe_pkg::MODE_STRING;
                end
            end
            jtfe_pkg::MODE_HEX:
            begin
                if (hex_cnt_reg != 2'd3)
                begin
                    cp_next      = cp_full[11:0];
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end
                else
                begin
                    mode_next    = jtfe_pkg::MODE_STRING;
                    hex_cnt_next = 2'd0;
                    cp_next      = 12'd0;
                end
            end
            default:
            begin
                mode_next = jtfe_pkg::MODE_SEARCH;
            end
        endcase
        // End of message: back to search
        if (last)
        begin
            mode_next    = jtfe_pkg::MODE_SEARCH;
            key_next     = 3'd0;
            hex_cnt_next = 2'd0;
            cp_next      = 12'd0;
        end
    end

    // Result group
    always_comb
    begin
        grp            = '0;
        grp.data_valid = 1'b1;
        unique case (mode_reg)
            jtfe_pkg::MODE_SEARCH:
            begin
                grp.cnt = 2'd0;
            end
            jtfe_pkg::MODE_STRING:
            begin
                if (c == CH_BSL)
                begin
                    if (last)
                    begin
                        grp.bytes[0] = c;
                        grp.cnt      = 2'd1;
                    end
                end
                else if (c != CH_QUOTE)
                begin
                    grp.bytes[0] = c;
                    grp.cnt      = 2'd1;
                end
            end
            jtfe_pkg::MODE_ESCAPE:
            begin
                grp.cnt = 2'd1;
                unique case (c)
                    8'h62:   grp.bytes[0] = 8'h08;
                    8'h66:   grp.bytes[0] = 8'h0C;
                    8'h6E:   grp.bytes[0] = 8'h0A;
                    8'h72:   grp.bytes[0] = 8'h0D;
                    8'h74:   grp.bytes[0] = 8'h09;
                    CH_U:    grp.cnt      = 2'd0;
                    default: grp.bytes[0] = c;
                endcase
            end
            jtfe_pkg::MODE_HEX:
            begin
                if (hex_cnt_reg == 2'd3)
                begin
                    if (cp_full < 16'h0080)
                    begin
                        grp.bytes[0] = cp_full[7:0];
                        grp.cnt      = 2'd1;
                    end
                    else if (cp_full < 16'h0800)
                    begin
                        grp.bytes[0] = 8'hC0 | {3'd0, cp_full[10:6]};
                        grp.bytes[1] = 8'h80 | {2'd0, cp_full[5:0]};
                        grp.cnt      = 2'd2;
                    end
                    else
                    begin
                        grp.bytes[0] = 8'hE0 | {4'd0, cp_full[15:12]};
                        grp.bytes[1] = 8'h80 | {2'd0, cp_full[11:6]};
                        grp.bytes[2] = 8'h80 | {2'd0, cp_full[5:0]};
                        grp.cnt      = 2'd3;
                    end
                end
            end
            default:
            begin
                grp.cnt = 2'd0;
            end
        endcase
        if (last)
        begin
            grp.done = 1'b1;
            if (grp.cnt == 2'd0)
            begin
                // bare end marker
                grp.cnt        = 2'd1;
                grp.data_valid = 1'b0;
                grp.bytes[0]   = 8'd0;
            end
        end
        push = accept && (grp.cnt != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= jtfe_pkg::MODE_SEARCH;
            key_reg     <= 3'd0;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 12'd0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            key_reg     <= key_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

// File: hw/rtl/jtfe_queue.sv
// ----------------------------------------------------------------------------
// jtfe_queue
// Short FIFO of result groups between the parser and the serialiser.
// ----------------------------------------------------------------------------
module jtfe_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jtfe_pkg::group_t wr_data,
    output logic             full,
    input  logic             pop,
    output jtfe_pkg::group_t rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    jtfe_pkg::group_t mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// File: hw/rtl/jtfe_back.sv
// ----------------------------------------------------------------------------
// jtfe_back
// Serialiser: takes one group from the queue and hands out its result items
// one per cycle while out_ready is high, marking group last and message end.
// ----------------------------------------------------------------------------
module jtfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  jtfe_pkg::group_t  q_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output jtfe_pkg::out_item_t out_data
);

    jtfe_pkg::group_t grp_reg;
    logic             have_reg;
    logic [1:0]       idx_reg;
    logic             is_last;
    logic             done_with_grp;

    assign is_last       = (idx_reg == grp_reg.cnt - 2'd1);
    assign done_with_grp = !have_reg || (out_ready && is_last);
    assign pop           = done_with_grp && !q_empty;
    assign out_valid     = have_reg;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    out_data.out_byte = grp_reg.bytes[0];
            2'd1:    out_data.out_byte = grp_reg.bytes[1];
            default: out_data.out_byte = grp_reg.bytes[2];
        endcase
        out_data.byte_valid = grp_reg.data_valid;
        out_data.run_last   = is_last;
        out_data.text_done  = grp_reg.done && is_last;
    end

    always_ff @(posedge clk)
    begin
        if (pop) grp_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (done_with_grp)
        begin
            have_reg <= !q_empty;
            idx_reg  <= 2'd0;
        end
        else if (out_ready)
        begin
            // advance within the group
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// File: hw/rtl/json_text_field_extractor.sv
// ----------------------------------------------------------------------------
// json_text_field_extractor
// Streams a JSON message and emits the decoded text of every "text" member.
// ----------------------------------------------------------------------------
// din carries one message byte per item (in_byte, msg_end marking the final
// byte). dout carries decoded text bytes one per item: byte_valid is 0 only
// on a bare end marker, run_last flags the last result caused by an input
// byte, and text_done flags the final result of a message.
// Each input byte yields zero to three result items (three for a \u escape
// at or above U+0800); every msg_end byte yields at least one.
// Throughput: one input byte per cycle while the output side keeps up and
// no byte expands into more than one result; output runs at one item per
// cycle while dout is ready, so a multi-byte UTF-8 sequence leaves one
// byte at a time. A result reaches dout by way of the group queue, which
// the parser writes, and then the serialiser register that the queue loads.
// When dout stalls, groups collect in the QUEUE_DEPTH-entry queue and din
// drops ready once it is full. Reset clears the parser to key search and
// empties the queue; nothing needs filling before the first byte.
// ----------------------------------------------------------------------------
module json_text_field_extractor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    jtfe_stream_if.sink   din,
    jtfe_stream_if.source dout
);

    jtfe_pkg::group_t fr_grp;
    jtfe_pkg::group_t q_grp;
    logic             fr_push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    jtfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (din.valid),
        .in_ready   (din.ready),
        .in_data    (din.data),
        .queue_full (q_full),
        .push       (fr_push),
        .grp        (fr_grp)
    );

    jtfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fr_push),
        .wr_data (fr_grp),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_grp),
        .empty   (q_empty)
    );

    jtfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_grp),
        .pop       (q_pop),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .out_data  (dout.data)
    );

endmodule
